// ----- rtl/core/ill_pkg.sv -----
package ill_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned ACTION_W   = 3;
  localparam int unsigned POSITION_W = 6;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned COUNT_W    = 5;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH       = 3'd0,
    ACT_POP        = 3'd1,
    ACT_INSERT_AT  = 3'd2,
    ACT_REMOVE_AT  = 3'd3,
    ACT_INSERT_MID = 3'd4,
    ACT_REMOVE_MID = 3'd5,
    ACT_READ_AT    = 3'd6
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_INVALID = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    logic load_word;
    logic take_left;
    logic take_right;
  } cell_ctl_t;

endpackage

// ----- rtl/core/ill_req_if.sv -----
interface ill_req_if;
  logic                                  valid;
  logic                                  ready;
  logic [ill_pkg::ACTION_W-1:0]          action;
  logic signed [ill_pkg::POSITION_W-1:0] position;
  logic signed [ill_pkg::WORD_W-1:0]     word_in;

  modport source (output valid, output action, output position, output word_in, input ready);
  modport sink (input valid, input action, input position, input word_in, output ready);
endinterface

// ----- rtl/core/ill_rsp_if.sv -----
interface ill_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [ill_pkg::STATUS_W-1:0]      status;
  logic [ill_pkg::COUNT_W-1:0]       count_out;
  logic signed [ill_pkg::WORD_W-1:0] word_out;

  modport source (output valid, output status, output count_out, output word_out, input ready);
  modport sink (input valid, input status, input count_out, input word_out, output ready);
endinterface

// ----- rtl/core/ill_cell.sv -----
module ill_cell (
  input  logic                            clk,
  input  ill_pkg::cell_ctl_t              ctl,
  input  logic [ill_pkg::WORD_W-1:0]      word,
  input  logic [ill_pkg::WORD_W-1:0]      left,
  input  logic [ill_pkg::WORD_W-1:0]      right,
  output logic [ill_pkg::WORD_W-1:0]      data
);

  always_ff @(posedge clk) begin
    if (ctl.load_word) begin
      data <= word;
    end else if (ctl.take_left) begin
      data <= left;
    end else if (ctl.take_right) begin
      data <= right;
    end
  end

endmodule

// ----- rtl/core/indexed_insert_remove_list.sv -----
// Channel   | Direction | Payload
// request   | in        | action, position, word_in
// response  | out       | status, count_out, word_out
//
// All cells shift toward or away from the selected index in parallel, so the
// list accepts one request per clock while the response register can take it.
// The response is held in an output register; a new request is taken while
// that register is empty or being drained in the same cycle.
// Reset clears the element count and the response valid; cell contents are
// not reset and are only read after being written.
module indexed_insert_remove_list #(
  parameter int unsigned DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  ill_req_if.sink          request,
  ill_rsp_if.source        response
);

  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned IW   = $clog2(DEPTH);
  localparam int unsigned CMPW = (CW > 5) ? CW : 5;
  localparam int unsigned W    = ill_pkg::WORD_W;

  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic            out_valid;
  logic [ill_pkg::STATUS_W-1:0] out_status;
  logic [ill_pkg::COUNT_W-1:0]  out_count;
  logic [W-1:0]    out_word;

  logic            in_fire;
  logic [CMPW-1:0] count_ext;
  logic [CMPW-1:0] pos_ext;
  logic [CMPW-1:0] mid_ext;
  logic [CMPW-1:0] at_sel;
  logic            pos_ok;
  logic            is_full;
  logic            is_empty;
  logic            do_insert;
  logic            do_remove;
  logic            do_pop;
  ill_pkg::status_t status_next;
  logic [W-1:0]    read_word;
  logic [W-1:0]    word_next;

  logic [W-1:0]        cell_data [DEPTH];
  ill_pkg::cell_ctl_t  cell_ctl  [DEPTH];

  assign in_fire       = request.valid && request.ready;
  assign request.ready = !out_valid || response.ready;

  assign count_ext = CMPW'(count);
  assign pos_ext   = CMPW'(request.position[ill_pkg::POSITION_W-2:0]);
  assign mid_ext   = count_ext >> 1;
  assign pos_ok    = !request.position[ill_pkg::POSITION_W-1] && (pos_ext < count_ext);
  assign is_full   = count_ext == CMPW'(DEPTH);
  assign is_empty  = count_ext == '0;
  assign read_word = cell_data[IW'(pos_ext)];

  always_comb begin
    status_next = ill_pkg::ST_OK;
    at_sel      = pos_ext;
    do_insert   = 1'b0;
    do_remove   = 1'b0;
    do_pop      = 1'b0;
    word_next   = '0;
    unique case (ill_pkg::action_t'(request.action))
      ill_pkg::ACT_PUSH: begin
        at_sel = count_ext;
        if (is_full) begin
          status_next = ill_pkg::ST_FULL;
        end else begin
          do_insert = 1'b1;
        end
      end
      ill_pkg::ACT_POP: begin
        if (is_empty) begin
          status_next = ill_pkg::ST_EMPTY;
        end else begin
          do_pop = 1'b1;
        end
      end
      ill_pkg::ACT_INSERT_AT: begin
        if (!pos_ok) begin
          status_next = ill_pkg::ST_INVALID;
        end else if (is_full) begin
          status_next = ill_pkg::ST_FULL;
        end else begin
          do_insert = 1'b1;
        end
      end
      ill_pkg::ACT_REMOVE_AT: begin
        if (!pos_ok) begin
          status_next = ill_pkg::ST_INVALID;
        end else begin
          do_remove = 1'b1;
        end
      end
      ill_pkg::ACT_INSERT_MID: begin
        at_sel = mid_ext;
        if (is_empty) begin
          status_next = ill_pkg::ST_INVALID;
        end else if (is_full) begin
          status_next = ill_pkg::ST_FULL;
        end else begin
          do_insert = 1'b1;
        end
      end
      ill_pkg::ACT_REMOVE_MID: begin
        at_sel = mid_ext;
        if (is_empty) begin
          status_next = ill_pkg::ST_EMPTY;
        end else begin
          do_remove = 1'b1;
        end
      end
      ill_pkg::ACT_READ_AT: begin
        if (!pos_ok) begin
          status_next = ill_pkg::ST_INVALID;
        end else begin
          word_next = read_word;
        end
      end
      default: begin
        status_next = ill_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    count_next = count;
    if (do_insert) begin
      count_next = count + CW'(1);
    end else if (do_remove || do_pop) begin
      count_next = count - CW'(1);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic         hit;
    logic         above;
    logic [W-1:0] left_data;
    logic [W-1:0] right_data;

    assign hit   = at_sel == CMPW'(i);
    assign above = at_sel < CMPW'(i);

    assign cell_ctl[i].load_word  = in_fire && do_insert && hit;
    assign cell_ctl[i].take_left  = in_fire && do_insert && above;
    assign cell_ctl[i].take_right = in_fire && do_remove && (hit || above);

    if (i == 0) begin : g_first
      assign left_data = '0;
    end else begin : g_inner_left
      assign left_data = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_data = cell_data[i];
    end else begin : g_inner_right
      assign right_data = cell_data[i+1];
    end

    ill_cell u_cell (
      .clk   (clk),
      .ctl   (cell_ctl[i]),
      .word  (request.word_in),
      .left  (left_data),
      .right (right_data),
      .data  (cell_data[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (response.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_status <= status_next;
      out_count  <= ill_pkg::COUNT_W'(CMPW'(count_next));
      out_word   <= word_next;
    end
  end

  assign response.valid     = out_valid;
  assign response.status    = out_status;
  assign response.count_out = out_count;
  assign response.word_out  = out_word;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("element count exceeds capacity");

  a_fire_gives_response: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("accepted request produced no response");

  a_fail_keeps_count: assert property (@(posedge clk) disable iff (rst)
    in_fire && (status_next != ill_pkg::ST_OK) |=> $stable(count))
    else $error("failed action changed the element count");

  a_response_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_count == ill_pkg::COUNT_W'(CMPW'(count))))
    else $error("reported count differs from stored count");

endmodule

// ----- test/tb_indexed_insert_remove_list.sv -----
import ill_pkg::*;

typedef struct packed {
  status_t            status;
  logic [COUNT_W-1:0] count;
  logic [WORD_W-1:0]  word;
} list_outcome_t;

class list_shadow #(int CAP = 16);
  logic [WORD_W-1:0] cells [CAP];
  int                count;
  int                mismatches;
  list_outcome_t     awaited [$];

  function new();
    count = 0;
    mismatches = 0;
  endfunction

  function int pending();
    return awaited.size();
  endfunction

  function void open_slot(int at, logic [WORD_W-1:0] w);
    for (int i = count; i > at; i--) begin
      cells[i] = cells[i - 1];
    end
    cells[at] = w;
    count++;
  endfunction

  function void close_slot(int at);
    for (int i = at; i + 1 < count; i++) begin
      cells[i] = cells[i + 1];
    end
    count--;
  endfunction

  // Works out the response to one accepted request and updates the shadow list.
  function void apply_request(logic [ACTION_W-1:0] act, logic signed [POSITION_W-1:0] pos,
                              logic [WORD_W-1:0] w);
    list_outcome_t r;
    bit            pos_ok;
    r.status = ST_OK;
    r.word = '0;
    pos_ok = (pos >= 0) && (int'(pos) < count);
    case (act)
      ACT_PUSH: begin
        if (count >= CAP) r.status = ST_FULL;
        else open_slot(count, w);
      end
      ACT_POP: begin
        if (count == 0) r.status = ST_EMPTY;
        else count--;
      end
      ACT_INSERT_AT: begin
        if (!pos_ok) r.status = ST_INVALID;
        else if (count >= CAP) r.status = ST_FULL;
        else open_slot(int'(pos), w);
      end
      ACT_REMOVE_AT: begin
        if (!pos_ok) r.status = ST_INVALID;
        else close_slot(int'(pos));
      end
      ACT_INSERT_MID: begin
        if (count == 0) r.status = ST_INVALID;
        else if (count >= CAP) r.status = ST_FULL;
        else open_slot(count / 2, w);
      end
      ACT_REMOVE_MID: begin
        if (count == 0) r.status = ST_EMPTY;
        else close_slot(count / 2);
      end
      ACT_READ_AT: begin
        if (!pos_ok) r.status = ST_INVALID;
        else r.word = cells[int'(pos)];
      end
      default: begin
      end
    endcase
    r.count = count[COUNT_W-1:0];
    awaited.push_back(r);
  endfunction

  function void compare_response(logic [STATUS_W-1:0] st, logic [COUNT_W-1:0] cnt,
                                 logic [WORD_W-1:0] w);
    list_outcome_t e;
    if (awaited.size() == 0) begin
      $display("%0t: response with no request outstanding, actual status %0d count %0d word %0d",
               $time, st, cnt, $signed(w));
      mismatches++;
    end else begin
      e = awaited.pop_front();
      if (st !== e.status) begin
        $display("%0t: status mismatch, expected %0d, actual %0d", $time, e.status, st);
        mismatches++;
      end
      if (cnt !== e.count) begin
        $display("%0t: count_out mismatch, expected %0d, actual %0d", $time, e.count, cnt);
        mismatches++;
      end
      if (w !== e.word) begin
        $display("%0t: word_out mismatch, expected %0d, actual %0d", $time,
                 $signed(e.word), $signed(w));
        mismatches++;
      end
    end
  endfunction
endclass

module tb_indexed_insert_remove_list;
  localparam int LIST_DEPTH = 16;
  localparam int RANDOM_REQUESTS = 600;
  localparam int STALL_LIMIT = 2000;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;
  localparam int MODE_GROW = 0;
  localparam int MODE_SHRINK = 1;
  localparam int MODE_MIXED = 2;

  logic clk = 1'b0;
  logic rst;
  bit   steady_flow;
  int   quiet_cycles;

  ill_req_if req_ch ();
  ill_rsp_if rsp_ch ();

  list_shadow #(LIST_DEPTH) shadow;

  indexed_insert_remove_list #(.DEPTH(LIST_DEPTH)) uut (
    .clk(clk),
    .rst(rst),
    .request(req_ch),
    .response(rsp_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(negedge clk) begin
    rsp_ch.ready <= steady_flow || ($urandom_range(99) >= 25);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        shadow.apply_request(req_ch.action, req_ch.position, req_ch.word_in);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        shadow.compare_response(rsp_ch.status, rsp_ch.count_out, rsp_ch.word_out);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Entered and left at a falling edge.
  task automatic send_request(input logic [ACTION_W-1:0] act, input int pos,
                              input logic [WORD_W-1:0] w);
    while (!steady_flow && $urandom_range(99) < 25) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.action <= act;
    req_ch.position <= pos[POSITION_W-1:0];
    req_ch.word_in <= w;
    @(posedge clk);
    while (!(req_ch.valid && req_ch.ready)) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  function automatic logic [ACTION_W-1:0] pick_action(int mode);
    int r;
    r = $urandom_range(99);
    case (mode)
      MODE_GROW: begin
        if (r < 30) return ACT_PUSH;
        if (r < 50) return ACT_INSERT_AT;
        if (r < 65) return ACT_INSERT_MID;
        if (r < 72) return ACT_POP;
        if (r < 78) return ACT_REMOVE_AT;
        if (r < 84) return ACT_REMOVE_MID;
      end
      MODE_SHRINK: begin
        if (r < 8) return ACT_PUSH;
        if (r < 14) return ACT_INSERT_AT;
        if (r < 18) return ACT_INSERT_MID;
        if (r < 40) return ACT_POP;
        if (r < 62) return ACT_REMOVE_AT;
        if (r < 78) return ACT_REMOVE_MID;
      end
      default: begin
        if (r < 18) return ACT_PUSH;
        if (r < 32) return ACT_INSERT_AT;
        if (r < 42) return ACT_INSERT_MID;
        if (r < 54) return ACT_POP;
        if (r < 68) return ACT_REMOVE_AT;
        if (r < 78) return ACT_REMOVE_MID;
      end
    endcase
    if (r < 98) return ACT_READ_AT;
    return ACT_UNUSED;
  endfunction

  function automatic int pick_position(int cnt);
    if (cnt > 0 && $urandom_range(99) < 80) return $urandom_range(cnt - 1);
    return int'($urandom_range(17)) - 1;
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int mode;
    shadow = new();
    steady_flow = 1'b0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.action = ACT_PUSH;
    req_ch.position = '0;
    req_ch.word_in = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // The empty list first, then a few elements with extreme values.
    send_request(ACT_READ_AT, 0, 32'h0);
    send_request(ACT_POP, 0, 32'h0);
    send_request(ACT_REMOVE_MID, 0, 32'h0);
    send_request(ACT_INSERT_AT, 0, 32'h1234_5678);
    send_request(ACT_INSERT_MID, 0, 32'h1234_5678);
    send_request(ACT_REMOVE_AT, -1, 32'h0);
    send_request(ACT_REMOVE_AT, 0, 32'h0);
    send_request(ACT_UNUSED, 5, 32'hdead_beef);
    send_request(ACT_PUSH, 0, 32'h7fff_ffff);
    send_request(ACT_PUSH, 0, 32'h8000_0000);
    send_request(ACT_INSERT_AT, 0, 32'hffff_ffff);
    send_request(ACT_INSERT_MID, 0, 32'h0);
    send_request(ACT_INSERT_AT, -1, 32'h5555_5555);
    send_request(ACT_INSERT_AT, 4, 32'haaaa_aaaa);
    send_request(ACT_READ_AT, 0, 32'h0);
    send_request(ACT_READ_AT, 3, 32'h0);
    send_request(ACT_READ_AT, -1, 32'h0);
    send_request(ACT_READ_AT, 4, 32'h0);
    send_request(ACT_READ_AT, 16, 32'h0);
    send_request(ACT_REMOVE_AT, 16, 32'h0);
    send_request(ACT_REMOVE_AT, 1, 32'h0);
    send_request(ACT_REMOVE_MID, 0, 32'h0);
    send_request(ACT_UNUSED, -1, 32'h0);
    send_request(ACT_POP, 0, 32'h0);

    mode = MODE_GROW;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n > 0 && n % 40 == 0) mode = $urandom_range(2);
      steady_flow = (n >= 250 && n < 350);
      send_request(pick_action(mode), pick_position(shadow.count), pick_word());
    end
    steady_flow = 1'b0;
    req_ch.valid <= 1'b0;

    while (shadow.pending() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
    if (shadow.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
